FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising edge of clk, ignoring cycles held in reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that cond in one cycle implies result in the next cycle.
`define ASSERT_NEXT(label, clk, rst, cond, result, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (result)) \
      else $error(msg);

`endif

FILE: hdl/toeq_pkg.sv
// ----------------------------------------------------------------------------
// toeq_pkg
// Types and codes shared by the time-ordered event queue modules.
// ----------------------------------------------------------------------------
package toeq_pkg;

   localparam int TIME_BITS  = 32;
   localparam int TAG_BITS   = 16;
   localparam int INDEX_BITS = 4;
   localparam int TOTAL_BITS = 5;
   localparam int OP_BITS    = 2;

   localparam logic [OP_BITS-1:0] OP_PUSH = 2'd0;
   localparam logic [OP_BITS-1:0] OP_POP  = 2'd1;
   localparam logic [OP_BITS-1:0] OP_READ = 2'd2;

   typedef struct packed {
      logic [OP_BITS-1:0]    op;
      logic [TIME_BITS-1:0]  event_time;
      logic [TAG_BITS-1:0]   event_tag;
      logic [INDEX_BITS-1:0] read_index;
   } req_type;

   typedef struct packed {
      logic                  item_valid;
      logic [TIME_BITS-1:0]  item_time;
      logic [TAG_BITS-1:0]   item_tag;
      logic [TOTAL_BITS-1:0] entry_total;
      logic                  fault;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;   // latch the request beat
      logic execute;   // apply the operation and register the response
   } cmd_type;

endpackage

FILE: hdl/toeq_controller.sv
// ----------------------------------------------------------------------------
// toeq_controller
// Sequencer: accepts a request beat, runs the execute state, raises the strobe.
// ----------------------------------------------------------------------------
module toeq_controller
   import toeq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   output logic    rsp_strobe,
   output cmd_type cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic state_ff;
   logic state_in;
   logic strobe_ff;
   logic strobe_in;

   always_comb begin
      cmd.capture = start && (state_ff == ST_IDLE);
      cmd.execute = (state_ff == ST_EXEC);
      strobe_in   = cmd.execute;
      case (state_ff)
         ST_IDLE: begin
            state_in = cmd.capture ? ST_EXEC : ST_IDLE;
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   assign busy       = (state_ff == ST_EXEC);
   assign rsp_strobe = strobe_ff;

endmodule

FILE: hdl/toeq_datapath.sv
// ----------------------------------------------------------------------------
// toeq_datapath
// Sorted row of event cells with parallel compare, entry count and response.
// ----------------------------------------------------------------------------
module toeq_datapath
   import toeq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
)
(
   input  logic    clock,
   input  logic    reset,
   input  cmd_type cmd,
   input  req_type req_data,
   output rsp_type rsp_data
);

   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam int EXT_BITS = CNT_BITS + INDEX_BITS;

   req_type              req_ff;
   logic [TIME_BITS-1:0] time_ff [QUEUE_DEPTH];
   logic [TAG_BITS-1:0]  tag_ff  [QUEUE_DEPTH];
   logic [TIME_BITS-1:0] time_in [QUEUE_DEPTH];
   logic [TAG_BITS-1:0]  tag_in  [QUEUE_DEPTH];
   logic [TIME_BITS-1:0] up_time [QUEUE_DEPTH];
   logic [TAG_BITS-1:0]  up_tag  [QUEUE_DEPTH];
   logic [CNT_BITS-1:0]  count_ff;
   logic [CNT_BITS-1:0]  count_in;
   rsp_type              rsp_ff;
   rsp_type              rsp_in;

   logic [QUEUE_DEPTH-1:0] le;
   logic [QUEUE_DEPTH-1:0] prev_le;
   logic                   full;
   logic                   empty;
   logic                   push_ok;
   logic                   pop_ok;
   logic                   in_range;
   logic [EXT_BITS-1:0]    read_ext;
   logic [EXT_BITS-1:0]    count_ext;
   logic [EXT_BITS-1:0]    total_ext;
   logic [TIME_BITS-1:0]   sel_time;
   logic [TAG_BITS-1:0]    sel_tag;

   always_comb begin
      full      = (count_ff == CNT_BITS'(QUEUE_DEPTH));
      empty     = (count_ff == '0);
      push_ok   = (req_ff.op == OP_PUSH) && !full;
      pop_ok    = (req_ff.op == OP_POP) && !empty;
      read_ext  = {{CNT_BITS{1'b0}}, req_ff.read_index};
      count_ext = {{INDEX_BITS{1'b0}}, count_ff};
      in_range  = (read_ext < count_ext);

      // Occupied cells at or before the new time stay put.
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         le[i] = (CNT_BITS'(i) < count_ff) && (time_ff[i] <= req_ff.event_time);
      end
      prev_le[0] = 1'b1;
      for (int i = 1; i < QUEUE_DEPTH; i++) begin
         prev_le[i] = le[i-1];
      end
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
         up_time[i] = time_ff[i+1];
         up_tag[i]  = tag_ff[i+1];
      end
      up_time[QUEUE_DEPTH-1] = time_ff[QUEUE_DEPTH-1];
      up_tag[QUEUE_DEPTH-1]  = tag_ff[QUEUE_DEPTH-1];

      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         time_in[i] = time_ff[i];
         tag_in[i]  = tag_ff[i];
         if (push_ok && !le[i]) begin
            if (prev_le[i]) begin
               time_in[i] = req_ff.event_time;
               tag_in[i]  = req_ff.event_tag;
            end else if (i > 0) begin
               time_in[i] = time_ff[(i > 0) ? i - 1 : 0];
               tag_in[i]  = tag_ff[(i > 0) ? i - 1 : 0];
            end
         end else if (pop_ok) begin
            time_in[i] = up_time[i];
            tag_in[i]  = up_tag[i];
         end
      end

      sel_time = '0;
      sel_tag  = '0;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         if (EXT_BITS'(i) == read_ext) begin
            sel_time = time_ff[i];
            sel_tag  = tag_ff[i];
         end
      end

      count_in = count_ff;
      if (push_ok) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (pop_ok) begin
         count_in = count_ff - CNT_BITS'(1);
      end
      total_ext = {{INDEX_BITS{1'b0}}, count_in};

      // Default: refused operation, report the current head.
      rsp_in.fault      = 1'b1;
      rsp_in.item_valid = !empty;
      rsp_in.item_time  = empty ? '0 : time_ff[0];
      rsp_in.item_tag   = empty ? '0 : tag_ff[0];
      case (req_ff.op)
         OP_PUSH: begin
            if (push_ok) begin
               rsp_in.fault      = 1'b0;
               rsp_in.item_valid = 1'b1;
               if (!le[0]) begin
                  rsp_in.item_time = req_ff.event_time;
                  rsp_in.item_tag  = req_ff.event_tag;
               end
            end
         end
         OP_POP: begin
            if (pop_ok) begin
               rsp_in.fault      = 1'b0;
               rsp_in.item_valid = (count_ff > CNT_BITS'(1));
               rsp_in.item_time  = (count_ff > CNT_BITS'(1)) ? time_ff[1] : '0;
               rsp_in.item_tag   = (count_ff > CNT_BITS'(1)) ? tag_ff[1] : '0;
            end
         end
         OP_READ: begin
            rsp_in.fault      = !in_range;
            rsp_in.item_valid = in_range;
            rsp_in.item_time  = in_range ? sel_time : '0;
            rsp_in.item_tag   = in_range ? sel_tag : '0;
         end
         default: begin
         end
      endcase
      rsp_in.entry_total = total_ext[TOTAL_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.execute) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
      if (cmd.execute) begin
         rsp_ff <= rsp_in;
         for (int i = 0; i < QUEUE_DEPTH; i++) begin
            time_ff[i] <= time_in[i];
            tag_ff[i]  <= tag_in[i];
         end
      end
   end

   assign rsp_data = rsp_ff;

endmodule

FILE: hdl/time_ordered_event_queue.sv
// ----------------------------------------------------------------------------
// time_ordered_event_queue
// Bounded event queue kept sorted by time, earliest event at the head.
// ----------------------------------------------------------------------------
//
//   channel   handshake           payload      direction
//   request   start / busy        req_data     in
//   response  rsp_strobe          rsp_data     out
//
// A request beat is taken when start is high and busy is low. The next cycle
// applies the push, pop or read to the whole row of cells at once (every cell
// compares its time with the new one in parallel), so busy is high for that
// one cycle. The response beat follows on rsp_strobe for exactly one cycle;
// a request beat may be taken in that same cycle, giving one item every two
// cycles. Reset is synchronous and clears the entry count and the sequencer;
// stored cells hold whatever they held and are only read below the count.
// The receiver cannot stall: the response beat is gone after its cycle.
//
module time_ordered_event_queue
   import toeq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   cmd_type cmd;

   // Sequence each beat: capture, execute, strobe.
   toeq_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd)
   );

   // Hold the sorted cells and build the response.
   toeq_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule

FILE: hdl/toeq_checker.sv
// ----------------------------------------------------------------------------
// toeq_checker
// Port-level checks on the event queue, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module toeq_checker
   import toeq_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_data,
   input logic    rsp_strobe,
   input rsp_type rsp_data
);

   logic accept;
   assign accept = start && !busy && (req_data.op == req_data.op);

   `ASSERT_NEXT(a_busy_after_accept, clock, reset, accept, busy, "busy missing after accept")
   `ASSERT_CLK(a_rsp_two_after, clock, reset, accept |-> ##2 rsp_strobe, "response beat late")
   `ASSERT_CLK(a_rsp_when_free, clock, reset, rsp_strobe |-> !busy, "strobe while busy")
   `ASSERT_CLK(a_empty_item_zero, clock, reset,
      (rsp_strobe && !rsp_data.item_valid) |->
      (rsp_data.item_time == '0 && rsp_data.item_tag == '0), "invalid item not zero")

endmodule

bind time_ordered_event_queue toeq_checker u_toeq_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_data   (req_data),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);
